// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RVMD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rvmd assertion failed");

// Next-cycle implication, disabled during reset.
`define RVMD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rvmd assertion failed");

`endif

// ===== rtl/rvmd_pkg.sv =====
package rvmd_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned WLEN = 32;
  localparam int unsigned NUM_CELLS = XLEN;

  localparam logic [2:0] FN_MUL    = 3'd0;
  localparam logic [2:0] FN_MULH   = 3'd1;
  localparam logic [2:0] FN_MULHSU = 3'd2;
  localparam logic [2:0] FN_MULHU  = 3'd3;
  localparam logic [2:0] FN_DIV    = 3'd4;
  localparam logic [2:0] FN_DIVU   = 3'd5;
  localparam logic [2:0] FN_REM    = 3'd6;
  localparam logic [2:0] FN_REMU   = 3'd7;

  typedef struct packed {
    logic [2:0]      opcode;
    logic            word_op;
    logic [XLEN-1:0] operand_a;
    logic [XLEN-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic [XLEN-1:0] result_value;
    logic            illegal;
  } out_t;

  typedef enum logic [2:0] {
    SEL_MUL_LO,
    SEL_MUL_HI,
    SEL_QUOT,
    SEL_REM,
    SEL_ZERO
  } sel_t;

  typedef struct packed {
    logic is_div;
    sel_t sel;
    logic word;
    logic neg;
    logic div_zero;
  } ctrl_t;

  // Working set of one cell: hi is the upper product or partial remainder,
  // x the multiplier/low product or dividend/quotient, y the multiplicand
  // or divisor.
  typedef struct packed {
    ctrl_t           ctrl;
    logic [XLEN-1:0] hi;
    logic [XLEN-1:0] x;
    logic [XLEN-1:0] y;
  } cell_t;

endpackage

// ===== rtl/rvmd_prep.sv =====
module rvmd_prep (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_ok,
  input  rvmd_pkg::in_t   din,
  output logic            vld,
  output rvmd_pkg::cell_t dout
);

  logic [63:0] am, bm, neg_a, neg_b, mag_a, mag_b;
  logic        signed_a, signed_b, sa, sb, illegal;
  rvmd_pkg::cell_t cell_next;

  always_comb begin
    am = din.word_op ? {32'b0, din.operand_a[31:0]} : din.operand_a;
    bm = din.word_op ? {32'b0, din.operand_b[31:0]} : din.operand_b;
    illegal = din.word_op && (din.opcode == rvmd_pkg::FN_MULH ||
              din.opcode == rvmd_pkg::FN_MULHSU || din.opcode == rvmd_pkg::FN_MULHU);
    signed_a = din.opcode == rvmd_pkg::FN_MULH || din.opcode == rvmd_pkg::FN_MULHSU ||
               din.opcode == rvmd_pkg::FN_DIV || din.opcode == rvmd_pkg::FN_REM;
    signed_b = din.opcode == rvmd_pkg::FN_MULH || din.opcode == rvmd_pkg::FN_DIV ||
               din.opcode == rvmd_pkg::FN_REM;
    sa = signed_a && (din.word_op ? am[31] : am[63]);
    sb = signed_b && (din.word_op ? bm[31] : bm[63]);
    neg_a = -am;
    neg_b = -bm;
    if (din.word_op) begin
      neg_a[63:32] = '0;
      neg_b[63:32] = '0;
    end
    mag_a = sa ? neg_a : am;
    mag_b = sb ? neg_b : bm;

    cell_next.ctrl.is_div   = din.opcode[2];
    cell_next.ctrl.word     = din.word_op;
    cell_next.ctrl.div_zero = (bm == '0);
    cell_next.ctrl.neg      = 1'b0;
    cell_next.ctrl.sel      = rvmd_pkg::SEL_ZERO;
    unique case (din.opcode)
      rvmd_pkg::FN_MUL: begin
        cell_next.ctrl.sel = rvmd_pkg::SEL_MUL_LO;
      end
      rvmd_pkg::FN_MULH, rvmd_pkg::FN_MULHSU, rvmd_pkg::FN_MULHU: begin
        cell_next.ctrl.sel = rvmd_pkg::SEL_MUL_HI;
        cell_next.ctrl.neg = sa ^ sb;
      end
      rvmd_pkg::FN_DIV, rvmd_pkg::FN_DIVU: begin
        cell_next.ctrl.sel = rvmd_pkg::SEL_QUOT;
        cell_next.ctrl.neg = sa ^ sb;
      end
      default: begin
        cell_next.ctrl.sel = rvmd_pkg::SEL_REM;
        cell_next.ctrl.neg = sa;
      end
    endcase
    if (illegal) begin
      cell_next.ctrl.sel = rvmd_pkg::SEL_ZERO;
    end
    cell_next.hi = '0;
    // Multiply: x is the multiplier, y the multiplicand. Divide: x is the dividend.
    cell_next.x = din.opcode[2] ? mag_a : mag_b;
    cell_next.y = din.opcode[2] ? mag_b : mag_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= cell_next;
    end
  end

endmodule

// ===== rtl/rvmd_cell.sv =====
module rvmd_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vld_in,
  input  rvmd_pkg::cell_t cin,
  output logic            vld,
  output rvmd_pkg::cell_t dout
);

  logic [64:0] rem, diff, sum;
  logic        ge;
  rvmd_pkg::cell_t cell_next;

  always_comb begin
    cell_next = cin;
    rem  = {cin.hi, cin.x[63]};
    diff = rem - {1'b0, cin.y};
    ge   = rem >= {1'b0, cin.y};
    sum  = {1'b0, cin.hi} + (cin.x[0] ? {1'b0, cin.y} : 65'd0);
    if (cin.ctrl.is_div) begin
      // One restoring division step; the remainder stays below twice the divisor.
      cell_next.hi = ge ? diff[63:0] : rem[63:0];
      cell_next.x  = {cin.x[62:0], ge};
    end else begin
      // One shift-add step; low product bits shift into x as the multiplier drains.
      cell_next.hi = sum[64:1];
      cell_next.x  = {sum[0], cin.x[63:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= cell_next;
    end
  end

endmodule

// ===== rtl/rvmd_post.sv =====
`include "assert_macros.svh"

module rvmd_post (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vld_in,
  input  rvmd_pkg::cell_t cin,
  output logic            out_valid,
  output rvmd_pkg::out_t  out_data
);

  logic [127:0] prod, prod_s;
  logic [63:0]  quot, rmd, res;
  rvmd_pkg::out_t out_next;
  logic           word_q;

  always_comb begin
    prod   = {cin.hi, cin.x};
    prod_s = cin.ctrl.neg ? -prod : prod;
    quot   = cin.ctrl.neg ? -cin.x : cin.x;
    if (cin.ctrl.div_zero) begin
      quot = '1;
    end
    rmd = cin.ctrl.neg ? -cin.hi : cin.hi;
    unique case (cin.ctrl.sel)
      rvmd_pkg::SEL_MUL_LO: res = prod_s[63:0];
      rvmd_pkg::SEL_MUL_HI: res = prod_s[127:64];
      rvmd_pkg::SEL_QUOT:   res = quot;
      rvmd_pkg::SEL_REM:    res = rmd;
      default:              res = '0;
    endcase
    if (cin.ctrl.word) begin
      res = {{32{res[31]}}, res[31:0]};
    end
    out_next.result_value = res;
    out_next.illegal      = (cin.ctrl.sel == rvmd_pkg::SEL_ZERO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
      word_q   <= cin.ctrl.word;
    end
  end

  `RVMD_ASSERT_IMP(a_illegal_zero, clk, rst, out_valid && out_data.illegal,
                   out_data.result_value == '0)
  `RVMD_ASSERT_IMP(a_word_sext, clk, rst, out_valid && word_q,
                   out_data.result_value[63:32] == {32{out_data.result_value[31]}})

endmodule

// ===== rtl/rv64m_multiply_divide_unit_core.sv =====
// RV64M multiply/divide unit.
// Input channel in_valid/in_stall/in_data carries one instruction per
// transaction: funct3 opcode, word flag and two 64-bit operands. Output
// channel out_valid/out_stall/out_data returns one transaction per input,
// the 64-bit result and an illegal flag, in input order.
// The datapath has one operand preparation stage, a chain of 64 cells
// that each perform one shift-add multiply step or one restoring divide
// step, and one result formatting stage that also serves as output register.
// Throughput is one instruction per cycle unless out_stall holds the chain;
// every instruction, multiply or divide, travels the same 64-cell chain.
// While out_valid is high and out_stall is asserted the whole chain holds
// and in_stall is raised; no transaction is dropped.
// A synchronous reset clears all valid bits; the data registers are not
// reset, and the block is ready to accept on the first cycle after reset.
`include "assert_macros.svh"

module rv64m_multiply_divide_unit_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rvmd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rvmd_pkg::out_t out_data
);

  localparam int unsigned N = rvmd_pkg::NUM_CELLS;

  logic            en;
  logic [N:0]      vld;
  rvmd_pkg::cell_t stage [0:N];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  rvmd_prep u_prep (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .in_ok(in_valid),
    .din  (in_data),
    .vld  (vld[0]),
    .dout (stage[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    rvmd_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .vld_in(vld[i]),
      .cin   (stage[i]),
      .vld   (vld[i+1]),
      .dout  (stage[i+1])
    );
  end

  rvmd_post u_post (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (vld[N]),
    .cin      (stage[N]),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  `RVMD_ASSERT_NEXT(a_hold_count, clk, rst, !en,
                    $countones(vld) == $past($countones(vld)))

endmodule
